@@ hw/rtl/rgbetm_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbetm_pkg
// Shared types, widths and constants of the RGBE filmic tone mapper,
// including the gamma 1/1.8 table built at elaboration.
// ----------------------------------------------------------------------------
package rgbetm_pkg;

  localparam int GammaTableDepth = 1024;
  localparam int LinearFracBits  = 16;

  localparam int IdxBits   = $clog2(GammaTableDepth);
  localparam int LinW      = 8 + LinearFracBits;
  localparam int ProdW     = 24;
  localparam int TW        = 26;
  localparam int NumW      = LinW + TW;
  localparam int DivW      = NumW + IdxBits;
  localparam int NumStages = 8 + IdxBits;
  localparam int ExpOffset = 148 - LinearFracBits;

  localparam logic [15:0]        GainReset = 16'd4096;
  localparam logic [15:0]        Scale06   = 16'd39322;
  localparam logic [17:0]        CurveA    = 18'd164495;
  localparam logic [17:0]        CurveB    = 18'd1966;
  localparam logic [17:0]        CurveC    = 18'd159252;
  localparam logic [17:0]        CurveD    = 18'd38666;
  localparam logic [17:0]        CurveE    = 18'd9175;
  localparam logic [IdxBits-1:0] IdxMax    = IdxBits'(GammaTableDepth - 1);

  typedef struct packed {
    logic [7:0] red_mant;
    logic [7:0] green_mant;
    logic [7:0] blue_mant;
    logic [7:0] shared_exp;
    logic       frame_end_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end_out;
  } out_item_t;

  typedef logic [GammaTableDepth-1:0][7:0] gamma_lut_t;

  // entry i: largest v with v^9 * (D-1)^5 <= i^5 * 255^9
  function automatic gamma_lut_t gamma_table();
    gamma_lut_t  lut;
    logic [159:0] lhs;
    logic [159:0] rhs;
    int           v;
    int           i;
    int           k;
    logic         done;
    v = 0;
    for (i = 0; i < GammaTableDepth; i++) begin
      rhs = 160'd1;
      for (k = 0; k < 5; k++) rhs = rhs * 160'(i);
      for (k = 0; k < 9; k++) rhs = rhs * 160'd255;
      done = 1'b0;
      while (v < 255 && !done) begin
        lhs = 160'd1;
        for (k = 0; k < 9; k++) lhs = lhs * 160'(v + 1);
        for (k = 0; k < 5; k++) lhs = lhs * 160'(GammaTableDepth - 1);
        if (lhs > rhs) begin
          done = 1'b1;
        end else begin
          v = v + 1;
        end
      end
      lut[i] = 8'(v);
    end
    return lut;
  endfunction

  localparam gamma_lut_t GammaLut = gamma_table();

endpackage

@@ hw/rtl/rgbetm_lane.sv @@
// ----------------------------------------------------------------------------
// rgbetm_lane
// One color channel: decode, exposure, filmic curve, restoring divider
// one quotient bit per stage, gamma lookup. Stage k loads when en_i[k].
// ----------------------------------------------------------------------------
module rgbetm_lane (
  input  logic                               clk_i,
  input  logic [rgbetm_pkg::NumStages-1:0]   en_i,
  input  logic [7:0]                         mant_i,
  input  logic [7:0]                         exp_i,
  input  logic [15:0]                        gain_i,
  output logic [7:0]                         pix_o
);
  import rgbetm_pkg::*;

  localparam int ShW = $clog2(ProdW + LinW);

  logic [7:0]             mant_q, exp_q;
  logic [ProdW-1:0]       prod_q;
  logic [9:0]             shift_q;
  logic [LinW-1:0]        lin_d, lin_q;
  logic [LinW+15:0]       xprod;
  logic [LinW-1:0]        x3_q, x4_q;
  logic [LinW+18:0]       tprod, uprod;
  logic [TW-1:0]          t_q, u_q;
  logic [NumW-1:0]        num_q, den_q5;
  logic [NumW:0]          den_sum;
  logic [DivW-1:0]        rem_q [IdxBits+1];
  logic [NumW-1:0]        den_q [IdxBits+1];
  logic [IdxBits-1:0]     quo_q [IdxBits+1];
  logic                   sat_q [IdxBits+1];
  logic [IdxBits-1:0]     idx;
  logic [7:0]             pix_q;
  logic [ProdW+LinW-1:0]  wide;
  logic [9:0]             ramt;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      mant_q <= mant_i;
      exp_q  <= exp_i;
    end
    if (en_i[1]) begin
      prod_q  <= ProdW'(mant_q) * ProdW'(gain_i);
      shift_q <= 10'(exp_q) - 10'(ExpOffset);
    end
  end

  always_comb begin
    lin_d = '0;
    wide  = '0;
    ramt  = 10'd0 - shift_q;
    if (!shift_q[9]) begin
      if (shift_q >= 10'(LinW)) begin
        lin_d = (prod_q != '0) ? '1 : '0;
      end else begin
        wide  = (ProdW + LinW)'(prod_q) << shift_q[ShW-1:0];
        lin_d = (wide > (ProdW + LinW)'({LinW{1'b1}})) ? '1 : LinW'(wide);
      end
    end else if (ramt < 10'(ProdW)) begin
      lin_d = LinW'(prod_q >> ramt[ShW-1:0]);
    end
  end

  assign xprod = (LinW + 16)'(lin_q) * (LinW + 16)'(Scale06);
  assign tprod = (LinW + 19)'(CurveA) * (LinW + 19)'(x3_q)
               + ((LinW + 19)'(CurveB) << LinearFracBits);
  assign uprod = (LinW + 19)'(CurveC) * (LinW + 19)'(x3_q)
               + ((LinW + 19)'(CurveD) << LinearFracBits);
  assign den_sum = (NumW + 1)'(NumW'(x4_q) * NumW'(u_q))
                 + ((NumW + 1)'(CurveE) << LinearFracBits);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) lin_q <= lin_d;
    if (en_i[3]) x3_q <= xprod[LinW+15:16];
    if (en_i[4]) begin
      x4_q <= x3_q;
      t_q  <= TW'(tprod >> LinearFracBits);
      u_q  <= TW'(uprod >> LinearFracBits);
    end
    if (en_i[5]) begin
      num_q  <= NumW'(x4_q) * NumW'(t_q);
      den_q5 <= den_sum[NumW-1:0];
    end
    if (en_i[6]) begin
      rem_q[0] <= DivW'(num_q) * DivW'(IdxMax);
      den_q[0] <= den_q5;
      quo_q[0] <= '0;
      sat_q[0] <= (num_q >= den_q5);
    end
  end

  for (genvar j = 0; j < IdxBits; j++) begin : g_div
    localparam int Bit = IdxBits - 1 - j;
    logic [DivW-1:0] dsh;
    logic            ge;
    assign dsh = DivW'(den_q[j]) << Bit;
    assign ge  = (rem_q[j] >= dsh);
    always_ff @(posedge clk_i) begin
      if (en_i[7+j]) begin
        rem_q[j+1] <= ge ? rem_q[j] - dsh : rem_q[j];
        den_q[j+1] <= den_q[j];
        quo_q[j+1] <= quo_q[j] | (ge ? IdxBits'(1) << Bit : '0);
        sat_q[j+1] <= sat_q[j];
      end
    end
  end

  assign idx = sat_q[IdxBits] ? IdxMax : quo_q[IdxBits];

  always_ff @(posedge clk_i) begin
    if (en_i[NumStages-1]) pix_q <= GammaLut[idx];
  end

  assign pix_o = pix_q;

endmodule

@@ hw/rtl/rgbe_filmic_tone_mapper.sv @@
// ----------------------------------------------------------------------------
// rgbe_filmic_tone_mapper
// RGBE pixel to 8-bit RGB through exposure, filmic curve and gamma 1/1.8.
//
//   channel  | handshake                  | payload
//   input    | in_valid_i / in_stall_o    | in_item_i  (in_item_t)
//   output   | out_valid_o / out_stall_i  | out_item_o (out_item_t)
//   config   | cfg_we_i                   | cfg_wdata_i (exposure gain, Q4.12)
//
// One item per cycle while in_stall_o is low; the divider yields one
// quotient bit per stage.
// Reset clears valid bits and sets the gain to 1.0.
// Empty stages keep filling under output stall; input stalls only when
// every stage holds an item.
// ----------------------------------------------------------------------------
module rgbe_filmic_tone_mapper (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  rgbetm_pkg::in_item_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rgbetm_pkg::out_item_t out_item_o,
  input  logic                  cfg_we_i,
  input  logic [15:0]           cfg_wdata_i
);
  import rgbetm_pkg::*;

  logic [15:0]          gain_q;
  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] fe_q;
  logic [NumStages:0]   en;
  logic [7:0]           red, green, blue;

  always_comb begin
    en[NumStages] = !out_stall_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GainReset;
      vld_q  <= '0;
    end else begin
      if (cfg_we_i) gain_q <= cfg_wdata_i;
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) fe_q[0] <= in_item_i.frame_end_in;
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) fe_q[k] <= fe_q[k-1];
    end
  end

  rgbetm_lane u_red (
    .clk_i, .en_i(en[NumStages-1:0]), .mant_i(in_item_i.red_mant),
    .exp_i(in_item_i.shared_exp), .gain_i(gain_q), .pix_o(red)
  );
  rgbetm_lane u_green (
    .clk_i, .en_i(en[NumStages-1:0]), .mant_i(in_item_i.green_mant),
    .exp_i(in_item_i.shared_exp), .gain_i(gain_q), .pix_o(green)
  );
  rgbetm_lane u_blue (
    .clk_i, .en_i(en[NumStages-1:0]), .mant_i(in_item_i.blue_mant),
    .exp_i(in_item_i.shared_exp), .gain_i(gain_q), .pix_o(blue)
  );

  assign in_stall_o               = !en[0];
  assign out_valid_o              = vld_q[NumStages-1];
  assign out_item_o.red_out       = red;
  assign out_item_o.green_out     = green;
  assign out_item_o.blue_out      = blue;
  assign out_item_o.frame_end_out = fe_q[NumStages-1];

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vld_q) && out_stall_i)
    else $error("input stalled with an empty stage");

  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled item changed");

  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> gain_q == $past(cfg_wdata_i))
    else $error("gain write lost");

endmodule
